FILE: hdl/page_frame_replacer_with_slot_map_macros.svh
// Assertion macros used by the checker of the page frame replacer.
// No dependencies; include by bare file name.
`ifndef PAGE_FRAME_REPLACER_WITH_SLOT_MAP_MACROS_SVH
`define PAGE_FRAME_REPLACER_WITH_SLOT_MAP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pfr assertion failed");

// Next-cycle implication, disabled during reset
`define PFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pfr assertion failed");

`endif

FILE: hdl/pfr_pkg.sv
// Shared types and codes of the page frame replacer.
// No dependencies; imported by the top level, its checker and the testbench.
package pfr_pkg;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_MARK   = 2'd1,
        OP_FREE   = 2'd2,
        OP_ALLOC  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_HIT       = 3'd0,
        KIND_WRITEBACK = 3'd1,
        KIND_LOADED    = 3'd2,
        KIND_ALLOCATED = 3'd3,
        KIND_FULL      = 3'd4,
        KIND_DONE      = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FSCAN,
        ST_FOUND,
        ST_CLEAN,
        ST_WB_RD,
        ST_WB_EMIT,
        ST_VIC_RD,
        ST_VIC_EMIT,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_ALLOC,
        ST_ALLOC_WR,
        ST_FULL
    } state_t;

    localparam logic [9:0] SMB_RESET = 10'd512;

endpackage

FILE: hdl/page_frame_replacer_with_slot_map.sv
// Top level of the page frame replacer: LRU frame pool plus swap slot bitmap.
// Depends on pfr_pkg.
//
// One word is worked on at a time. After reset the slot bitmap memory is cleared one
// byte a cycle, with s_tready low. Per word: a frame lookup streams the frame slot
// memory one frame a cycle in recency order; a miss adds the clean search over the
// oldest FRAMES/3 frames, a write-back sweep (read, then emit) of every frame when no
// clean frame is found, and the refill (victim read, then emit). Allocate streams the
// bitmap memory one byte a cycle, up to swap_map_bytes bytes capped at the map size.
// Free adds a bitmap read-modify-write before the lookup when the slot is in range. The
// output register lets the next result wait while the caller stalls m_tready.
module page_frame_replacer_with_slot_map
    import pfr_pkg::*;
#(
    parameter int FRAMES = 16,
    parameter int SLOTS  = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: operation[1:0], slot[13:2], modified[14], nonempty[15]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // tdata: slot_out[11:0], frame[15:12], victim_slot[27:16], victim_valid[28],
    //        read_needed[29], zero[31:30]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // tuser: kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW    = $clog2(FRAMES);
    localparam int PW    = $clog2(FRAMES + 1);
    localparam int CW    = $clog2(FRAMES / 3 + 1);
    localparam int BYTES = (SLOTS + 7) / 8;
    localparam int BW    = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int LW    = BW + 1;

    // control state
    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [FW-1:0]     cmp_pos_reg, cmp_pos_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic [FW-1:0]     hp_reg, hp_next;
    logic [LW-1:0]     bidx_reg, bidx_next;
    logic              bcmp_valid_reg, bcmp_valid_next;
    logic [BW-1:0]     bcmp_idx_reg, bcmp_idx_next;
    logic [9:0]        smb_reg, smb_next;
    logic [FW-1:0]     rec_reg [FRAMES];
    logic [FW-1:0]     rec_next [FRAMES];
    logic [FRAMES-1:0] holds_reg, holds_next;
    logic [FRAMES-1:0] dirty_reg, dirty_next;
    logic [FRAMES-1:0] data_reg, data_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // payload
    logic [1:0]        op_reg, op_next;
    logic [11:0]       s_reg, s_next;
    logic              mod_reg, mod_next;
    logic              ne_reg, ne_next;
    logic [BW-1:0]     abyte_reg, abyte_next;
    logic [2:0]        abit_reg, abit_next;
    logic [7:0]        aval_reg, aval_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;
    logic [2:0]        m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    // memories
    logic [11:0]       fslot_mem [FRAMES];
    logic [7:0]        bm_mem [BYTES];
    logic [11:0]       fs_rd;
    logic [7:0]        bm_rd;
    logic              fm_we;
    logic [FW-1:0]     fm_waddr, fm_raddr;
    logic              bm_we;
    logic [BW-1:0]     bm_waddr, bm_raddr;
    logic [7:0]        bm_wdata;

    // helpers
    logic              out_free;
    logic              emit;
    logic [2:0]        e_kind;
    logic [11:0]       e_slot;
    logic [FW-1:0]     e_frame;
    logic [11:0]       e_vslot;
    logic              e_vvalid;
    logic              e_read;
    logic              e_last;
    logic              tf_en;
    logic [FW-1:0]     tf_pos;
    logic [FW-1:0]     cur_pos;
    logic [FW-1:0]     cur_f;
    logic [FW-1:0]     cmp_f;
    logic [LW-1:0]     limit;
    logic [2:0]        zbit;
    logic              slot_in_range;
    logic              cfg_wr;

    assign out_free      = !m_tvalid_reg || m_tready;
    assign cur_pos       = (pos_reg < PW'(FRAMES)) ? pos_reg[FW-1:0] : '0;
    assign cur_f         = rec_reg[cur_pos];
    assign cmp_f         = rec_reg[cmp_pos_reg];
    assign limit         = (32'(smb_reg) > BYTES) ? LW'(BYTES) : LW'(smb_reg);
    assign slot_in_range = 32'(s_reg) < SLOTS;
    assign cfg_wr        = psel && penable && pwrite && (paddr[2] == 1'b0);

    // lowest clear bit of the byte under compare
    always_comb begin
        zbit = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!bm_rd[i]) begin
                zbit = 3'(i);
            end
        end
    end

    // frame slot memory
    always_ff @(posedge aclk) begin
        if (fm_we) begin
            fslot_mem[fm_waddr] <= s_reg;
        end
        fs_rd <= fslot_mem[fm_raddr];
    end

    // slot bitmap memory
    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_rd <= bm_mem[bm_raddr];
    end

    // sequencer: next state, memory strobes, results
    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_pos_next    = cmp_pos_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        hp_next         = hp_reg;
        bidx_next       = bidx_reg;
        bcmp_valid_next = bcmp_valid_reg;
        bcmp_idx_next   = bcmp_idx_reg;
        smb_next        = cfg_wr ? pwdata[9:0] : smb_reg;
        holds_next      = holds_reg;
        dirty_next      = dirty_reg;
        data_next       = data_reg;
        op_next         = op_reg;
        s_next          = s_reg;
        mod_next        = mod_reg;
        ne_next         = ne_reg;
        abyte_next      = abyte_reg;
        abit_next       = abit_reg;
        aval_next       = aval_reg;
        fm_we           = 1'b0;
        fm_waddr        = cur_f;
        fm_raddr        = cur_f;
        bm_we           = 1'b0;
        bm_waddr        = bidx_reg[BW-1:0];
        bm_raddr        = (bidx_reg < LW'(BYTES)) ? bidx_reg[BW-1:0] : '0;
        bm_wdata        = 8'd0;
        emit            = 1'b0;
        e_kind          = KIND_DONE;
        e_slot          = s_reg;
        e_frame         = '0;
        e_vslot         = 12'd0;
        e_vvalid        = 1'b0;
        e_read          = 1'b0;
        e_last          = 1'b1;
        tf_en           = 1'b0;
        tf_pos          = cur_pos;
        s_tready        = 1'b0;

        unique case (state_reg)
            // zero the bitmap after reset
            ST_CLEAR: begin
                bm_we = 1'b1;
                if (bidx_reg == LW'(BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
                bidx_next = bidx_reg + 1'b1;
            end

            // take a word and start its operation
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next         = s_tdata[1:0];
                    s_next          = s_tdata[13:2];
                    mod_next        = s_tdata[14];
                    ne_next         = s_tdata[15];
                    pos_next        = '0;
                    cmp_valid_next  = 1'b0;
                    bidx_next       = '0;
                    bcmp_valid_next = 1'b0;
                    unique case (op_t'(s_tdata[1:0]))
                        OP_ACCESS, OP_MARK: state_next = ST_FSCAN;
                        OP_FREE:            state_next = ST_FREE_RD;
                        OP_ALLOC:           state_next = ST_ALLOC;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end

            // stream frame slots in recency order, compare each read in the cycle after it is issued
            ST_FSCAN: begin
                if (cmp_valid_reg && holds_reg[cmp_f] && fs_rd == s_reg) begin
                    found_next = 1'b1;
                    hp_next    = cmp_pos_reg;
                    state_next = ST_FOUND;
                end else if (!cmp_valid_reg && pos_reg >= PW'(FRAMES)) begin
                    found_next = 1'b0;
                    if (op_t'(op_reg) == OP_ACCESS) begin
                        pos_next   = PW'(FRAMES - 1);
                        cnt_next   = CW'(FRAMES / 3);
                        state_next = ST_CLEAN;
                    end else begin
                        state_next = ST_FOUND;
                    end
                end else begin
                    cmp_valid_next = pos_reg < PW'(FRAMES);
                    cmp_pos_next   = cur_pos;
                    if (pos_reg < PW'(FRAMES)) begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end

            // finish hit, mark or free
            ST_FOUND: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_frame    = found_reg ? rec_reg[hp_reg] : '0;
                    state_next = ST_IDLE;
                    if (op_t'(op_reg) == OP_ACCESS) begin
                        e_kind = KIND_HIT;
                        tf_en  = 1'b1;
                        tf_pos = hp_reg;
                    end else if (found_reg && op_t'(op_reg) == OP_MARK) begin
                        dirty_next[rec_reg[hp_reg]] = mod_reg;
                        data_next[rec_reg[hp_reg]]  = ne_reg;
                    end else if (found_reg) begin
                        holds_next[rec_reg[hp_reg]] = 1'b0;
                        dirty_next[rec_reg[hp_reg]] = 1'b0;
                        data_next[rec_reg[hp_reg]]  = 1'b0;
                    end
                end
            end

            // search the oldest third for a clean frame
            ST_CLEAN: begin
                if (cnt_reg != '0 && dirty_reg[cur_f]) begin
                    cnt_next = cnt_reg - 1'b1;
                    pos_next = pos_reg - 1'b1;
                end else if (cnt_reg != '0) begin
                    state_next = ST_VIC_RD;
                end else begin
                    pos_next   = PW'(FRAMES - 1);
                    state_next = ST_WB_RD;
                end
            end

            // read slot of the frame at pos
            ST_WB_RD: begin
                state_next = ST_WB_EMIT;
            end

            // clean one frame, reporting a write-back for nonempty pages
            ST_WB_EMIT: begin
                if (!(holds_reg[cur_f] && dirty_reg[cur_f] && data_reg[cur_f]) || out_free) begin
                    if (holds_reg[cur_f] && dirty_reg[cur_f]) begin
                        dirty_next[cur_f] = 1'b0;
                        if (data_reg[cur_f]) begin
                            emit    = 1'b1;
                            e_kind  = KIND_WRITEBACK;
                            e_slot  = fs_rd;
                            e_frame = cur_f;
                            e_last  = 1'b0;
                        end
                    end
                    if (pos_reg == '0) begin
                        pos_next   = PW'(FRAMES - 1);
                        state_next = ST_VIC_RD;
                    end else begin
                        pos_next   = pos_reg - 1'b1;
                        state_next = ST_WB_RD;
                    end
                end
            end

            // read victim slot
            ST_VIC_RD: begin
                state_next = ST_VIC_EMIT;
            end

            // refill the victim and move it to the front
            ST_VIC_EMIT: begin
                if (out_free) begin
                    emit              = 1'b1;
                    e_kind            = KIND_LOADED;
                    e_frame           = cur_f;
                    e_vvalid          = holds_reg[cur_f];
                    e_vslot           = holds_reg[cur_f] ? fs_rd : 12'd0;
                    e_read            = ne_reg;
                    fm_we             = 1'b1;
                    holds_next[cur_f] = 1'b1;
                    dirty_next[cur_f] = 1'b0;
                    data_next[cur_f]  = ne_reg;
                    tf_en             = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            // read the bitmap byte of the freed slot
            ST_FREE_RD: begin
                bm_raddr = BW'(s_reg >> 3);
                if (slot_in_range) begin
                    state_next = ST_FREE_WR;
                end else begin
                    state_next = ST_FSCAN;
                end
            end

            // clear the slot bit
            ST_FREE_WR: begin
                bm_we      = 1'b1;
                bm_waddr   = BW'(s_reg >> 3);
                bm_wdata   = bm_rd & ~(8'd1 << s_reg[2:0]);
                state_next = ST_FSCAN;
            end

            // stream bitmap bytes until one has a clear bit
            ST_ALLOC: begin
                if (bcmp_valid_reg && bm_rd != 8'hFF) begin
                    abyte_next = bcmp_idx_reg;
                    abit_next  = zbit;
                    aval_next  = bm_rd | (8'd1 << zbit);
                    state_next = ST_ALLOC_WR;
                end else if (!bcmp_valid_reg && bidx_reg >= limit) begin
                    state_next = ST_FULL;
                end else begin
                    bcmp_valid_next = bidx_reg < limit;
                    bcmp_idx_next   = bm_raddr;
                    if (bidx_reg < limit) begin
                        bidx_next = bidx_reg + 1'b1;
                    end
                end
            end

            // set the slot bit and report it
            ST_ALLOC_WR: begin
                if (out_free) begin
                    bm_we      = 1'b1;
                    bm_waddr   = abyte_reg;
                    bm_wdata   = aval_reg;
                    emit       = 1'b1;
                    e_kind     = KIND_ALLOCATED;
                    e_slot     = 12'({abyte_reg, abit_reg});
                    state_next = ST_IDLE;
                end
            end

            // no free slot in the active map
            ST_FULL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = KIND_FULL;
                    e_slot     = 12'd0;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // move the frame at tf_pos to the front of the recency order
        for (int i = 0; i < FRAMES; i++) begin
            rec_next[i] = rec_reg[i];
            if (tf_en && i == 0) begin
                rec_next[i] = rec_reg[tf_pos];
            end else if (tf_en && i <= int'(tf_pos)) begin
                rec_next[i] = rec_reg[(i > 0) ? i - 1 : 0];
            end
        end

        // output register
        m_tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tdata_next = {2'b00, e_read, e_vvalid, e_vslot, 4'(e_frame), e_slot};
            m_tuser_next = e_kind;
            m_tlast_next = e_last;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            pos_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_pos_reg    <= '0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            hp_reg         <= '0;
            bidx_reg       <= '0;
            bcmp_valid_reg <= 1'b0;
            bcmp_idx_reg   <= '0;
            smb_reg        <= SMB_RESET;
            holds_reg      <= '0;
            dirty_reg      <= '0;
            data_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                rec_reg[i] <= FW'(i);
            end
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_pos_reg    <= cmp_pos_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            hp_reg         <= hp_next;
            bidx_reg       <= bidx_next;
            bcmp_valid_reg <= bcmp_valid_next;
            bcmp_idx_reg   <= bcmp_idx_next;
            smb_reg        <= smb_next;
            holds_reg      <= holds_next;
            dirty_reg      <= dirty_next;
            data_reg       <= data_next;
            m_tvalid_reg   <= m_tvalid_next;
            rec_reg        <= rec_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        s_reg       <= s_next;
        mod_reg     <= mod_next;
        ne_reg      <= ne_next;
        abyte_reg   <= abyte_next;
        abit_reg    <= abit_next;
        aval_reg    <= aval_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign prdata   = (paddr[2] == 1'b0) ? {22'd0, smb_reg} : 32'd0;
    assign pready   = 1'b1;

endmodule

FILE: hdl/pfr_checker.sv
// Port-level checker of the page frame replacer, bound to the top level.
// Depends on pfr_pkg and page_frame_replacer_with_slot_map_macros.svh.
`include "page_frame_replacer_with_slot_map_macros.svh"

module pfr_checker
    import pfr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // stalled word holds
    `PFR_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // only a write-back leaves the run open
    `PFR_ASSERT_IMP(a_last, aclk, aresetn, m_tvalid, m_tlast == (m_tuser != KIND_WRITEBACK))

    // victim and read flags appear on loads only
    `PFR_ASSERT_IMP(a_vic, aclk, aresetn, m_tvalid && m_tuser != KIND_LOADED, m_tdata[29:16] == 14'd0)

    // swap full carries no slot or frame
    `PFR_ASSERT_IMP(a_full, aclk, aresetn, m_tvalid && m_tuser == KIND_FULL, m_tdata[15:0] == 16'd0)

endmodule

bind page_frame_replacer_with_slot_map pfr_checker u_pfr_checker (.*);

FILE: test/tb.sv
// Self-checking testbench for page_frame_replacer_with_slot_map.
// Needs pfr_pkg and the top level; predicts every result word and checks it in order.
module tb
    import pfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = 16;
    localparam int NSLOTS = 4096;
    localparam logic [2:0] REG_SWAP_MAP_BYTES = 3'd0;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        kind_t       kind;
        logic [11:0] slot_out;
        logic [3:0]  frame;
        logic [11:0] victim_slot;
        logic        victim_valid;
        logic        read_needed;
        logic        last;
    } result_t;

    // Predictor of the frame pool and slot map, plus the store of pending results
    class frame_pool_scoreboard;
        logic        slot_taken [NSLOTS];
        logic [11:0] frame_slot [NF];
        logic        holds [NF];
        logic        dirty [NF];
        logic        has_data [NF];
        int          order [NF];
        int unsigned map_bytes;
        result_t     pending_results [$];
        int          mismatches;

        function new();
            for (int i = 0; i < NSLOTS; i++) slot_taken[i] = 1'b0;
            for (int i = 0; i < NF; i++) begin
                frame_slot[i] = '0;
                holds[i] = 1'b0;
                dirty[i] = 1'b0;
                has_data[i] = 1'b0;
                order[i] = i;
            end
            map_bytes = SMB_RESET;
            mismatches = 0;
        endfunction

        function void push(kind_t k, logic [11:0] s, int f, logic [11:0] vs,
                           logic vv, logic rd, logic lst);
            result_t r;
            r.kind = k;
            r.slot_out = s;
            r.frame = f[3:0];
            r.victim_slot = vs;
            r.victim_valid = vv;
            r.read_needed = rd;
            r.last = lst;
            pending_results.push_back(r);
        endfunction

        function void to_front(int pos);
            int f;
            f = order[pos];
            for (int p = pos; p > 0; p--) order[p] = order[p-1];
            order[0] = f;
        endfunction

        function int lookup(logic [11:0] s);
            for (int f = 0; f < NF; f++)
                if (holds[f] && frame_slot[f] == s) return f;
            return -1;
        endfunction

        function void access_page(logic [11:0] s, logic ne);
            int pos;
            int cnt;
            int f;
            logic vv;
            logic [11:0] vs;
            for (pos = 0; pos < NF; pos++) begin
                f = order[pos];
                if (holds[f] && frame_slot[f] == s) begin
                    to_front(pos);
                    push(KIND_HIT, s, f, '0, 1'b0, 1'b0, 1'b1);
                    return;
                end
            end
            // search the oldest third for a clean frame
            pos = NF - 1;
            cnt = NF / 3;
            while (cnt > 0 && dirty[order[pos]]) begin
                cnt--;
                pos--;
            end
            // none clean: sweep dirty frames oldest first, then take the oldest
            if (cnt <= 0) begin
                for (pos = NF - 1; pos >= 0; pos--) begin
                    f = order[pos];
                    if (holds[f] && dirty[f]) begin
                        if (has_data[f])
                            push(KIND_WRITEBACK, frame_slot[f], f, '0, 1'b0, 1'b0, 1'b0);
                        dirty[f] = 1'b0;
                    end
                end
                pos = NF - 1;
            end
            f = order[pos];
            vv = holds[f];
            vs = vv ? frame_slot[f] : '0;
            frame_slot[f] = s;
            holds[f] = 1'b1;
            dirty[f] = 1'b0;
            has_data[f] = ne;
            to_front(pos);
            push(KIND_LOADED, s, f, vs, vv, ne, 1'b1);
        endfunction

        function void note_word(logic [15:0] d);
            op_t op;
            logic [11:0] s;
            logic md;
            logic ne;
            int f;
            int unsigned lim;
            op = op_t'(d[1:0]);
            s = d[13:2];
            md = d[14];
            ne = d[15];
            case (op)
                OP_ACCESS: access_page(s, ne);
                OP_MARK: begin
                    f = lookup(s);
                    if (f >= 0) begin
                        dirty[f] = md;
                        has_data[f] = ne;
                    end
                    push(KIND_DONE, s, (f >= 0) ? f : 0, '0, 1'b0, 1'b0, 1'b1);
                end
                OP_FREE: begin
                    slot_taken[s] = 1'b0;
                    f = lookup(s);
                    if (f >= 0) begin
                        holds[f] = 1'b0;
                        dirty[f] = 1'b0;
                        has_data[f] = 1'b0;
                    end
                    push(KIND_DONE, s, (f >= 0) ? f : 0, '0, 1'b0, 1'b0, 1'b1);
                end
                default: begin
                    lim = map_bytes * 8;
                    if (lim > NSLOTS) lim = NSLOTS;
                    for (int t = 0; t < lim; t++) begin
                        if (!slot_taken[t]) begin
                            slot_taken[t] = 1'b1;
                            push(KIND_ALLOCATED, t[11:0], 0, '0, 1'b0, 1'b0, 1'b1);
                            return;
                        end
                    end
                    push(KIND_FULL, '0, 0, '0, 1'b0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void check_word(logic [2:0] kind, logic [31:0] data, logic lst);
            result_t got;
            result_t want;
            got.kind = kind_t'(kind);
            got.slot_out = data[11:0];
            got.frame = data[15:12];
            got.victim_slot = data[27:16];
            got.victim_valid = data[28];
            got.read_needed = data[29];
            got.last = lst;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: kind %0d data %h last %0d",
                             kind, data, lst);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want || data[31:30] !== 2'b00) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected kind %0d slot %0d frame %0d vslot %0d",
                             want.kind, want.slot_out, want.frame, want.victim_slot,
                             " vv %0d rd %0d last %0d",
                             want.victim_valid, want.read_needed, want.last);
                    $display("          got kind %0d slot %0d frame %0d vslot %0d",
                             kind, got.slot_out, got.frame, got.victim_slot,
                             " vv %0d rd %0d last %0d pad %b",
                             got.victim_valid, got.read_needed, got.last, data[31:30]);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_pool_scoreboard sb;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off_cycles;
    longint cycle_count;

    page_frame_replacer_with_slot_map u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check accepted words, then choose the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata, m_tlast);
        if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_SWAP_MAP_BYTES) sb.map_bytes = value[9:0];
    endtask

    // Wait for the block to go quiet before touching the register
    task automatic drain();
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic send_word(op_t op, logic [11:0] s, logic md, logic ne);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ne, md, s, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_word({ne, md, s, op});
    endtask

    task automatic send_random(int count);
        int r;
        logic [11:0] s;
        for (int i = 0; i < count; i++) begin
            // mostly a small page set so hits, sweeps and frees land on resident pages
            s = ($urandom_range(99) < 80) ? 12'($urandom_range(23)) : 12'($urandom);
            r = $urandom_range(99);
            if (r < 45)
                send_word(OP_ACCESS, s, 1'($urandom), 1'($urandom));
            else if (r < 70)
                send_word(OP_MARK, s, ($urandom_range(99) < 75), 1'($urandom));
            else if (r < 82)
                send_word(OP_FREE, s, 1'($urandom), 1'($urandom));
            else
                send_word(OP_ALLOC, 12'($urandom), 1'($urandom), 1'($urandom));
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 36;
        recv_idle_pct = 54;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: a one-byte map fills after eight slots
        apb_write(REG_SWAP_MAP_BYTES, 32'd1);
        repeat (9) send_word(OP_ALLOC, 12'd0, 1'b0, 1'b0);
        send_word(OP_FREE, 12'd3, 1'b0, 1'b0);
        send_word(OP_ALLOC, 12'hFFF, 1'b1, 1'b1);
        send_word(OP_MARK, 12'd100, 1'b1, 1'b1);
        send_word(OP_FREE, 12'hFFF, 1'b1, 1'b1);
        send_word(OP_ACCESS, 12'd0, 1'b0, 1'b1);
        send_word(OP_ACCESS, 12'd0, 1'b0, 1'b0);
        send_word(OP_MARK, 12'd0, 1'b1, 1'b1);
        send_word(OP_ACCESS, 12'hFFF, 1'b1, 1'b0);
        send_word(OP_FREE, 12'd0, 1'b0, 1'b0);
        s_tvalid <= 1'b0;
        drain();
        // no usable slot at all
        apb_write(REG_SWAP_MAP_BYTES, 32'd0);
        send_word(OP_ALLOC, 12'd0, 1'b0, 1'b0);
        s_tvalid <= 1'b0;
        drain();

        apb_write(REG_SWAP_MAP_BYTES, 32'd2);
        send_random(150);
        drain();

        send_idle_pct = 54;
        recv_idle_pct = 36;
        apb_write(REG_SWAP_MAP_BYTES, 32'd512);
        send_random(150);
        drain();

        // no idling, with one long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(REG_SWAP_MAP_BYTES, 32'd1023);
        hold_off_cycles = 400;
        send_random(150);
        drain();

        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
